[rtl/can_fs_pkg.sv]
package can_fs_pkg;

	localparam int MAX_DATA_BYTES_DEF = 8;
	localparam int CRC_W              = 15;
	localparam int LEN_W              = 4;
	localparam int ID_W               = 11;
	localparam int BYTE_W             = 8;
	// SOF + identifier + RTR + IDE + r0 + length
	localparam int HDR_BITS           = 1 + ID_W + 1 + 1 + 1 + LEN_W;
	localparam int TAIL_BITS          = 10;
	localparam int CNT_W              = $clog2(HDR_BITS + 1);

	localparam logic [CRC_W-1:0]     CRC_POLY = 15'h4599;
	// CRC delimiter, ack, ack delimiter, seven EOF bits, first bit on the left
	localparam logic [TAIL_BITS-1:0] TAIL_PAT = 10'b1011111111;

	localparam logic ACT_HEADER = 1'b0;
	localparam logic ACT_DATA   = 1'b1;

	typedef struct packed {
		logic              action;
		logic [ID_W-1:0]   frame_id;
		logic              remote_request;
		logic [LEN_W-1:0]  byte_count;
		logic [BYTE_W-1:0] data_byte;
	} req_t;

	typedef struct packed {
		logic line_bit;
		logic last_of_run;
		logic frame_done;
	} rsp_t;

	typedef enum logic [1:0] {
		STEP_HOLD,
		STEP_DATA,
		STEP_CRC,
		STEP_STUFF
	} step_kind_t;

	typedef struct packed {
		logic       init;
		step_kind_t kind;
		logic       bit_val;
	} step_cmd_t;

	typedef struct packed {
		logic             stuff_need;
		logic             stuff_bit;
		logic [CRC_W-1:0] crc_nxt;
	} step_stat_t;

endpackage

[rtl/can_frame_serializer_top.sv]
// channel | role   | handshake         | word
// req     | input  | req_valid/stall   | header (action 0) or data byte (action 1)
// rsp     | output | rsp_valid/stall   | one bus bit with last_of_run, frame_done
//
// One bus bit leaves per cycle, unless rsp_stall holds the output, through the shared
// stuff/CRC bit unit; an item is loaded before its first bit leaves. Header: 19 bits
// plus stuff bits; data byte: 8 to 10 bits; the closing item adds 15 CRC bits, up to 4
// stuff bits and 10 trailer bits. A data word with no open frame is taken and dropped.
// req_stall is high while an item is being serialized. rsp_stall holds the output
// register and the sequencer. Reset clears the frame and the output register.
module can_frame_serializer_top #(
	parameter int MAX_DATA_BYTES = can_fs_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  can_fs_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output can_fs_pkg::rsp_t rsp
);

	localparam int SH_W = can_fs_pkg::HDR_BITS;
	localparam int CW   = can_fs_pkg::CNT_W;
	localparam logic [can_fs_pkg::LEN_W-1:0] MAX_LEN = can_fs_pkg::LEN_W'(MAX_DATA_BYTES);

	typedef enum logic [1:0] {
		PH_FIELD,
		PH_CRC,
		PH_TAIL
	} phase_t;

	phase_t                        phase_q;
	logic [SH_W-1:0]               sh_q;
	logic [CW-1:0]                 cnt_q;
	logic                          busy_q;
	logic                          stuff_q;
	logic                          trail_q;
	logic                          open_q;
	logic [can_fs_pkg::LEN_W-1:0]  rem_q;
	logic                          rsp_valid_q;
	can_fs_pkg::rsp_t              rsp_q;

	can_fs_pkg::step_cmd_t         cmd;
	can_fs_pkg::step_stat_t        stat;

	logic                          req_acc;
	logic                          is_hdr;
	logic [can_fs_pkg::LEN_W-1:0]  len_sat;
	logic                          fire;
	logic                          emit_bit;
	logic                          phase_end;
	logic                          last_bit;
	logic                          done_bit;

	assign req_stall = busy_q;
	assign req_acc   = req_valid && !busy_q;
	assign is_hdr    = (req.action == can_fs_pkg::ACT_HEADER);
	assign fire      = busy_q && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (req.remote_request) begin
			len_sat = '0;
		end else if (req.byte_count > MAX_LEN) begin
			len_sat = MAX_LEN;
		end else begin
			len_sat = req.byte_count;
		end
	end

	always_comb begin
		cmd.init    = req_acc && is_hdr;
		cmd.kind    = can_fs_pkg::STEP_HOLD;
		cmd.bit_val = sh_q[SH_W-1];
		emit_bit    = sh_q[SH_W-1];
		phase_end   = 1'b0;
		if (fire) begin
			if (stuff_q) begin
				cmd.kind  = can_fs_pkg::STEP_STUFF;
				emit_bit  = stat.stuff_bit;
				phase_end = (cnt_q == '0);
			end else begin
				unique case (phase_q)
					PH_FIELD: begin
						cmd.kind  = can_fs_pkg::STEP_DATA;
						phase_end = (cnt_q == CW'(1)) && !stat.stuff_need;
					end
					PH_CRC: begin
						cmd.kind  = can_fs_pkg::STEP_CRC;
						phase_end = (cnt_q == CW'(1)) && !stat.stuff_need;
					end
					default: begin
						phase_end = (cnt_q == CW'(1));
					end
				endcase
			end
		end
		done_bit = phase_end && (phase_q == PH_TAIL);
		last_bit = done_bit || (phase_end && phase_q == PH_FIELD && !trail_q);
	end

	can_fs_bitstep u_bitstep (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIELD;
			sh_q        <= '0;
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			stuff_q     <= 1'b0;
			trail_q     <= 1'b0;
			open_q      <= 1'b0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (req_acc) begin
				if (is_hdr) begin
					sh_q    <= {1'b0, req.frame_id, req.remote_request, 2'b00, len_sat};
					cnt_q   <= CW'(can_fs_pkg::HDR_BITS);
					phase_q <= PH_FIELD;
					trail_q <= (len_sat == '0);
					open_q  <= (len_sat != '0);
					rem_q   <= len_sat;
					stuff_q <= 1'b0;
					busy_q  <= 1'b1;
				end else if (open_q && rem_q != '0) begin
					sh_q    <= {req.data_byte, (SH_W - can_fs_pkg::BYTE_W)'(0)};
					cnt_q   <= CW'(can_fs_pkg::BYTE_W);
					phase_q <= PH_FIELD;
					trail_q <= (rem_q == can_fs_pkg::LEN_W'(1));
					open_q  <= (rem_q != can_fs_pkg::LEN_W'(1));
					rem_q   <= rem_q - can_fs_pkg::LEN_W'(1);
					stuff_q <= 1'b0;
					busy_q  <= 1'b1;
				end
			end

			if (fire) begin
				if (phase_end) begin
					stuff_q <= 1'b0;
					unique case (phase_q)
						PH_FIELD: begin
							if (trail_q) begin
								phase_q <= PH_CRC;
								sh_q    <= {stat.crc_nxt, (SH_W - can_fs_pkg::CRC_W)'(0)};
								cnt_q   <= CW'(can_fs_pkg::CRC_W);
							end else begin
								busy_q <= 1'b0;
							end
						end
						PH_CRC: begin
							phase_q <= PH_TAIL;
							sh_q    <= {can_fs_pkg::TAIL_PAT,
								(SH_W - can_fs_pkg::TAIL_BITS)'(0)};
							cnt_q   <= CW'(can_fs_pkg::TAIL_BITS);
						end
						default: begin
							busy_q <= 1'b0;
						end
					endcase
				end else if (stuff_q) begin
					stuff_q <= 1'b0;
				end else begin
					sh_q    <= sh_q << 1;
					cnt_q   <= cnt_q - CW'(1);
					stuff_q <= (phase_q != PH_TAIL) && stat.stuff_need;
				end
				rsp_q       <= '{line_bit: emit_bit, last_of_run: last_bit, frame_done: done_bit};
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/can_fs_bitstep.sv]
module can_fs_bitstep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  can_fs_pkg::step_cmd_t  cmd,
	output can_fs_pkg::step_stat_t stat
);

	logic [can_fs_pkg::CRC_W-1:0] crc_q;
	logic [can_fs_pkg::CRC_W-1:0] crc_upd;
	logic [2:0]                   run_q;
	logic [2:0]                   run_nxt;
	logic                         prev_q;

	always_comb begin
		if (cmd.bit_val == prev_q && run_q != 3'd0) begin
			run_nxt = run_q + 3'd1;
		end else begin
			run_nxt = 3'd1;
		end
		crc_upd = {crc_q[can_fs_pkg::CRC_W-2:0], 1'b0}
			^ ((crc_q[can_fs_pkg::CRC_W-1] ^ cmd.bit_val) ? can_fs_pkg::CRC_POLY : '0);
	end

	assign stat.stuff_need = (run_nxt == 3'd5);
	assign stat.stuff_bit  = ~prev_q;
	assign stat.crc_nxt    = (cmd.kind == can_fs_pkg::STEP_DATA) ? crc_upd : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			run_q  <= 3'd0;
			prev_q <= 1'b1;
		end else if (cmd.init) begin
			crc_q  <= '0;
			run_q  <= 3'd0;
			prev_q <= 1'b1;
		end else begin
			unique case (cmd.kind)
				can_fs_pkg::STEP_DATA: begin
					crc_q  <= crc_upd;
					run_q  <= run_nxt;
					prev_q <= cmd.bit_val;
				end
				can_fs_pkg::STEP_CRC: begin
					run_q  <= run_nxt;
					prev_q <= cmd.bit_val;
				end
				can_fs_pkg::STEP_STUFF: begin
					// complement bit starts a new run of one
					run_q  <= 3'd1;
					prev_q <= ~prev_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/can_fs_checker.sv]
module can_fs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input can_fs_pkg::rsp_t rsp
);

	// a frame ends only on the last bit of an item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_done |-> rsp.last_of_run)
		else $error("frame_done without last_of_run");

	// final EOF bit is recessive
	a_done_recessive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_done |-> rsp.line_bit)
		else $error("frame_done on a dominant bit");

	// no new word is taken while the current item still has bits to send
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_of_run |-> req_stall)
		else $error("input accepted mid item");

	// a word accepted with no output pending shows no output in the next cycle
	a_load_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
		else $error("output appeared in the load cycle");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled output word changed");

endmodule

bind can_frame_serializer_top can_fs_checker u_can_fs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
